// File: hdl/rmq_pkg.sv
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 14;

  localparam int EW      = WORD_BITS + 2;
  localparam int A_W     = WORD_BITS + 1;
  localparam int RAD_W   = A_W + FRAC_BITS;
  localparam int SQ_N    = (RAD_W + 1) / 2;
  localparam int RAD_PAD = 2 * SQ_N;
  localparam int MAG_W   = WORD_BITS + 1;
  localparam int NUM_W   = MAG_W + FRAC_BITS;
  localparam int DEN_W   = SQ_N + 1;
  localparam int LANES   = 4;
  localparam int OUT_LAT = SQ_N + NUM_W + 3;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic [RAD_PAD-1:0] rad;
    logic [SQ_N-1:0]    root;
    logic [SQ_N:0]      rem;
  } sq_lane_t;

  typedef struct packed {
    logic                       vld;
    branch_t                    br;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
    sq_lane_t                   s;
    sq_lane_t                   h;
  } sq_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] rem;
  } dv_lane_t;

  typedef struct packed {
    logic                  vld;
    branch_t               br;
    logic [LANES-1:0]      neg;
    logic [LANES-1:0]      nz;
    logic                  zero;
    logic [SQ_N-1:0]       h;
    logic [DEN_W-1:0]      den;
    dv_lane_t [LANES-1:0]  ln;
  } dv_t;

  function automatic sq_lane_t sq_step(sq_lane_t a);
    logic [SQ_N+2:0] r2;
    logic [SQ_N+2:0] tr;
    logic [SQ_N+2:0] df;
    sq_lane_t o;
    r2 = {a.rem, a.rad[RAD_PAD-1 -: 2]};
    tr = {1'b0, a.root, 2'b01};
    df = r2 - tr;
    o.rad = {a.rad[RAD_PAD-3:0], 2'b00};
    if (r2 >= tr) begin
      o.rem  = df[SQ_N:0];
      o.root = {a.root[SQ_N-2:0], 1'b1};
    end else begin
      o.rem  = r2[SQ_N:0];
      o.root = {a.root[SQ_N-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_lane_t dv_step(dv_lane_t a, logic [DEN_W-1:0] den);
    logic [DEN_W:0] r2;
    logic [DEN_W:0] df;
    dv_lane_t o;
    r2 = {a.rem, a.num[NUM_W-1]};
    df = r2 - {1'b0, den};
    if (r2 >= {1'b0, den}) begin
      o.rem = df[DEN_W-1:0];
      o.num = {a.num[NUM_W-2:0], 1'b1};
    end else begin
      o.rem = r2[DEN_W-1:0];
      o.num = {a.num[NUM_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// File: hdl/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps

// Rotation matrix to quaternion.
// Command channel: m00..m22 (signed Q2.14, row major) are taken at a rising
// edge with start high and busy low. busy stays low: a new matrix may be
// issued in every cycle.
// Result channel: done is high for exactly one cycle with qw, qx, qy, qz
// (signed Q2.14), branch_taken and range_error. The transaction is taken
// at the edge that ends that cycle; the receiver cannot stall, so nothing
// ever holds the pipeline.
// Structure: an input stage, the root unit (16 stages, one root bit each),
// a divider load stage, the divider (31 stages, one quotient bit each) and
// an output stage. Throughput: one matrix per cycle.
// Reset (rst, synchronous): clears all pipeline valid bits; matrices in
// flight are dropped and no done follows them.
module rotation_matrix_to_quaternion (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rmq_pkg::WORD_BITS-1:0] m00,
  input  logic signed [rmq_pkg::WORD_BITS-1:0] m01,
  input  logic signed [rmq_pkg::WORD_BITS-1:0] m02,
  input  logic signed [rmq_pkg::WORD_BITS-1:0] m10,
  input  logic signed [rmq_pkg::WORD_BITS-1:0] m11,
  input  logic signed [rmq_pkg::WORD_BITS-1:0] m12,
  input  logic signed [rmq_pkg::WORD_BITS-1:0] m20,
  input  logic signed [rmq_pkg::WORD_BITS-1:0] m21,
  input  logic signed [rmq_pkg::WORD_BITS-1:0] m22,
  output logic                                done,
  output logic signed [rmq_pkg::WORD_BITS-1:0] qw,
  output logic signed [rmq_pkg::WORD_BITS-1:0] qx,
  output logic signed [rmq_pkg::WORD_BITS-1:0] qy,
  output logic signed [rmq_pkg::WORD_BITS-1:0] qz,
  output logic [1:0]                          branch_taken,
  output logic                                range_error
);

  localparam int W     = rmq_pkg::WORD_BITS;
  localparam int F     = rmq_pkg::FRAC_BITS;
  localparam int EW    = rmq_pkg::EW;
  localparam int SQ_N  = rmq_pkg::SQ_N;
  localparam int NUM_W = rmq_pkg::NUM_W;
  localparam int MAG_W = rmq_pkg::MAG_W;
  localparam int LANES = rmq_pkg::LANES;
  localparam int RP    = rmq_pkg::RAD_PAD;

  localparam logic signed [EW-1:0] ONE  = EW'(64'd1 << F);
  localparam logic [NUM_W-1:0]     QMAX = NUM_W'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [NUM_W-1:0]     QMNM = NUM_W'(64'd1 << (W - 1));

  assign busy = 1'b0;

  // input stage: branch select, root argument, numerators
  logic signed [EW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [EW-1:0] trace, a_val, dii, djj, dkk;
  logic [rmq_pkg::A_W-1:0] a_u;
  logic [rmq_pkg::RAD_W-1:0] rad;
  rmq_pkg::branch_t br;
  logic signed [EW-1:0] da [LANES];
  logic signed [EW-1:0] db [LANES];
  logic [LANES-1:0] sub;
  logic signed [EW-1:0] dsum [LANES];
  rmq_pkg::sq_t sq0;

  assign e00 = EW'(m00);
  assign e01 = EW'(m01);
  assign e02 = EW'(m02);
  assign e10 = EW'(m10);
  assign e11 = EW'(m11);
  assign e12 = EW'(m12);
  assign e20 = EW'(m20);
  assign e21 = EW'(m21);
  assign e22 = EW'(m22);

  always_comb begin
    trace = e00 + e11 + e22;
    if (trace > 0) begin
      br = rmq_pkg::BR_TRACE;
    end else if (m00 < m11) begin
      br = (m11 < m22) ? rmq_pkg::BR_Z : rmq_pkg::BR_Y;
    end else begin
      br = (m00 < m22) ? rmq_pkg::BR_Z : rmq_pkg::BR_X;
    end
    for (int l = 0; l < LANES; l++) begin
      da[l] = '0;
      db[l] = '0;
    end
    sub = '0;
    dii = e00;
    djj = e11;
    dkk = e22;
    case (br)
      rmq_pkg::BR_TRACE: begin
        da[1] = e12; db[1] = e21; sub[1] = 1'b1;
        da[2] = e20; db[2] = e02; sub[2] = 1'b1;
        da[3] = e01; db[3] = e10; sub[3] = 1'b1;
      end
      rmq_pkg::BR_X: begin
        da[0] = e12; db[0] = e21; sub[0] = 1'b1;
        da[2] = e01; db[2] = e10;
        da[3] = e02; db[3] = e20;
      end
      rmq_pkg::BR_Y: begin
        dii = e11; djj = e22; dkk = e00;
        da[0] = e20; db[0] = e02; sub[0] = 1'b1;
        da[3] = e12; db[3] = e21;
        da[1] = e10; db[1] = e01;
      end
      default: begin
        dii = e22; djj = e00; dkk = e11;
        da[0] = e01; db[0] = e10; sub[0] = 1'b1;
        da[1] = e20; db[1] = e02;
        da[2] = e21; db[2] = e12;
      end
    endcase
    if (br == rmq_pkg::BR_TRACE) begin
      a_val = trace + ONE;
    end else begin
      a_val = dii - djj - dkk + ONE;
    end
    a_u = a_val[EW-1] ? '0 : a_val[rmq_pkg::A_W-1:0];
    rad = {a_u, {F{1'b0}}};

    sq0.vld = start & ~busy & ~rst;
    sq0.br  = br;
    for (int l = 0; l < LANES; l++) begin
      dsum[l]    = sub[l] ? (da[l] - db[l]) : (da[l] + db[l]);
      sq0.neg[l] = dsum[l][EW-1];
      sq0.mag[l] = dsum[l][EW-1] ? MAG_W'(-dsum[l]) : MAG_W'(dsum[l]);
    end
    sq0.s.rad  = RP'(rad);
    sq0.h.rad  = RP'(rad >> 2);
    sq0.s.root = '0;
    sq0.h.root = '0;
    sq0.s.rem  = '0;
    sq0.h.rem  = '0;
  end

  // root pipeline
  rmq_pkg::sq_t sq [0:SQ_N];

  always_ff @(posedge clk) begin
    sq[0] <= sq0;
  end

  for (genvar k = 1; k <= SQ_N; k++) begin : g_sq
    rmq_pkg::sq_t sq_next;
    always_comb begin
      sq_next     = sq[k-1];
      sq_next.s   = rmq_pkg::sq_step(sq[k-1].s);
      sq_next.h   = rmq_pkg::sq_step(sq[k-1].h);
      sq_next.vld = sq[k-1].vld & ~rst;
    end
    always_ff @(posedge clk) begin
      sq[k] <= sq_next;
    end
  end

  // divider pipeline
  rmq_pkg::dv_t dv [0:NUM_W];

  always_ff @(posedge clk) begin
    dv[0].vld  <= rst ? 1'b0 : sq[SQ_N].vld;
    dv[0].br   <= sq[SQ_N].br;
    dv[0].neg  <= sq[SQ_N].neg;
    dv[0].h    <= sq[SQ_N].h.root;
    dv[0].den  <= {sq[SQ_N].s.root, 1'b0};
    dv[0].zero <= (sq[SQ_N].s.root == '0);
    for (int l = 0; l < LANES; l++) begin
      dv[0].nz[l]     <= (sq[SQ_N].mag[l] != '0);
      dv[0].ln[l].num <= {sq[SQ_N].mag[l], {F{1'b0}}};
      dv[0].ln[l].rem <= '0;
    end
  end

  for (genvar k = 1; k <= NUM_W; k++) begin : g_dv
    rmq_pkg::dv_t dv_next;
    always_comb begin
      dv_next = dv[k-1];
      for (int l = 0; l < LANES; l++) begin
        dv_next.ln[l] = rmq_pkg::dv_step(dv[k-1].ln[l], dv[k-1].den);
      end
      dv_next.vld = dv[k-1].vld & ~rst;
    end
    always_ff @(posedge clk) begin
      dv[k] <= dv_next;
    end
  end

  // sign, saturation, output register
  logic [W-1:0] res_next [LANES];
  logic [LANES-1:0] err_l;
  logic [NUM_W-1:0] qm;
  logic [NUM_W-1:0] qneg;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qm       = dv[NUM_W].ln[l].num;
      qneg     = -qm;
      err_l[l] = 1'b0;
      if (l == int'(dv[NUM_W].br)) begin
        res_next[l] = W'(dv[NUM_W].h);
      end else if (dv[NUM_W].zero) begin
        err_l[l] = 1'b1;
        if (!dv[NUM_W].nz[l]) begin
          res_next[l] = '0;
        end else begin
          res_next[l] = dv[NUM_W].neg[l] ? W'(QMNM) : W'(QMAX);
        end
      end else if (!dv[NUM_W].neg[l]) begin
        err_l[l]    = (qm > QMAX);
        res_next[l] = (qm > QMAX) ? W'(QMAX) : W'(qm);
      end else begin
        err_l[l]    = (qm > QMNM);
        res_next[l] = (qm > QMNM) ? W'(QMNM) : W'(qneg);
      end
    end
  end

  always_ff @(posedge clk) begin
    done         <= rst ? 1'b0 : dv[NUM_W].vld;
    qw           <= res_next[0];
    qx           <= res_next[1];
    qy           <= res_next[2];
    qz           <= res_next[3];
    branch_taken <= dv[NUM_W].br;
    range_error  <= |err_l;
  end

endmodule

// File: hdl/rmq_checker.sv
`timescale 1ns / 1ps

module rmq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic signed [rmq_pkg::WORD_BITS-1:0] qw,
  input logic signed [rmq_pkg::WORD_BITS-1:0] qx,
  input logic signed [rmq_pkg::WORD_BITS-1:0] qy,
  input logic signed [rmq_pkg::WORD_BITS-1:0] qz,
  input logic [1:0]                          branch_taken
);

  localparam int MSB = rmq_pkg::WORD_BITS - 1;

  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy asserted");

  a_rst_done: assert property (@(posedge clk) rst |=> !done)
    else $error("result transaction right after reset");

  a_latency: assert property (@(posedge clk)
    done |-> $past(start, rmq_pkg::OUT_LAT))
    else $error("result transaction without matching command");

  a_root_pos: assert property (@(posedge clk) done |->
    ((branch_taken == rmq_pkg::BR_TRACE) && !qw[MSB]) ||
    ((branch_taken == rmq_pkg::BR_X) && !qx[MSB]) ||
    ((branch_taken == rmq_pkg::BR_Y) && !qy[MSB]) ||
    ((branch_taken == rmq_pkg::BR_Z) && !qz[MSB]))
    else $error("root component negative");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
